[hdl/tllc_pkg.sv]
// ----------------------------------------------------------------------------
// tllc_pkg
// Shared types and constants of the texture level layout calculator: field
// widths, format and layout codes, status codes, register indexes and the
// surface and result records.
// ----------------------------------------------------------------------------
package tllc_pkg;

    // Field widths
    localparam int LEVEL_W    = 4;
    localparam int SIDE_W     = 11;
    localparam int OFFSET_W   = 20;
    localparam int BYTES_W    = 22;
    localparam int CODEBOOK_W = 12;
    localparam int COUNT_W    = 4;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int AREA_W     = 21;

    // VQ codebook sits in front of the texel data
    localparam logic [CODEBOOK_W-1:0] CODEBOOK_BYTES = 12'd2048;

    typedef enum logic [2:0] {
        FMT_ARGB1555 = 3'd0,
        FMT_RGB565   = 3'd1,
        FMT_ARGB4444 = 3'd2,
        FMT_YUV422   = 3'd3,
        FMT_BUMP     = 3'd4,
        FMT_PAL4     = 3'd5,
        FMT_PAL8     = 3'd6,
        FMT_INVALID  = 3'd7
    } t_fmt;

    typedef enum logic [1:0] {
        LAY_TWIDDLED = 2'd0,
        LAY_STRIDE   = 2'd1,
        LAY_VQ       = 2'd2,
        LAY_INVALID  = 2'd3
    } t_lay;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 2'd0,
        ST_INVALID_ARG   = 2'd1,
        ST_NOT_SUPPORTED = 2'd2,
        ST_LEVEL_RANGE   = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEX_WIDTH     = 3'd0,
        REG_TEX_HEIGHT    = 3'd1,
        REG_PIXEL_FORMAT  = 3'd2,
        REG_MEMORY_LAYOUT = 3'd3,
        REG_USE_MIPMAPS   = 3'd4
    } t_reg_idx;

    // Surface description held in the register file
    typedef struct packed {
        logic [SIDE_W-1:0] tex_width;
        logic [SIDE_W-1:0] tex_height;
        t_fmt              pixel_format;
        t_lay              memory_layout;
        logic              use_mipmaps;
    } t_cfg;

    // One answer to a level request
    typedef struct packed {
        t_status               status;
        logic [SIDE_W-1:0]     level_width;
        logic [SIDE_W-1:0]     level_height;
        logic [OFFSET_W-1:0]   level_offset;
        logic [BYTES_W-1:0]    level_bytes;
        logic [BYTES_W-1:0]    total_bytes;
        logic [BYTES_W-1:0]    data_bytes;
        logic [CODEBOOK_W-1:0] codebook_bytes;
        logic [COUNT_W-1:0]    level_count;
    } t_result;

endpackage

[hdl/tllc_if.sv]
// ----------------------------------------------------------------------------
// tllc_if
// Valid/ready channels of the layout calculator: configuration writes,
// level requests and results.
// ----------------------------------------------------------------------------
interface tllc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tllc_pkg::CFG_IDX_W-1:0]  index;
    logic [tllc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface tllc_req_if;
    logic                         valid;
    logic                         ready;
    logic [tllc_pkg::LEVEL_W-1:0] level;

    modport source (output valid, output level, input ready);
    modport sink   (input valid, input level, output ready);
endinterface

interface tllc_res_if;
    logic                            valid;
    logic                            ready;
    logic [tllc_pkg::STATUS_W-1:0]   status;
    logic [tllc_pkg::SIDE_W-1:0]     level_width;
    logic [tllc_pkg::SIDE_W-1:0]     level_height;
    logic [tllc_pkg::OFFSET_W-1:0]   level_offset;
    logic [tllc_pkg::BYTES_W-1:0]    level_bytes;
    logic [tllc_pkg::BYTES_W-1:0]    total_bytes;
    logic [tllc_pkg::BYTES_W-1:0]    data_bytes;
    logic [tllc_pkg::CODEBOOK_W-1:0] codebook_bytes;
    logic [tllc_pkg::COUNT_W-1:0]    level_count;

    modport source (
        output valid, output status, output level_width, output level_height,
        output level_offset, output level_bytes, output total_bytes,
        output data_bytes, output codebook_bytes, output level_count,
        input ready
    );
    modport sink (
        input valid, input status, input level_width, input level_height,
        input level_offset, input level_bytes, input total_bytes,
        input data_bytes, input codebook_bytes, input level_count,
        output ready
    );
endinterface

[hdl/tllc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// tllc_cfg_regs
// Surface description registers, written one at a time over the
// configuration channel. Writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module tllc_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tllc_cfg_if.sink       i_cfg,
    output tllc_pkg::t_cfg o_cfg
);
    import tllc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic w_wr;

    // Always take writes
    assign i_cfg.ready = 1'b1;
    assign w_wr        = i_cfg.valid;

    // Decode the register index
    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (t_reg_idx'(i_cfg.index))
                REG_TEX_WIDTH:     n_cfg.tex_width     = i_cfg.data;
                REG_TEX_HEIGHT:    n_cfg.tex_height    = i_cfg.data;
                REG_PIXEL_FORMAT:  n_cfg.pixel_format  = t_fmt'(i_cfg.data[2:0]);
                REG_MEMORY_LAYOUT: n_cfg.memory_layout = t_lay'(i_cfg.data[1:0]);
                REG_USE_MIPMAPS:   n_cfg.use_mipmaps   = i_cfg.data[0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tex_width     <= 11'd8;
            r_cfg.tex_height    <= 11'd8;
            r_cfg.pixel_format  <= FMT_ARGB1555;
            r_cfg.memory_layout <= LAY_TWIDDLED;
            r_cfg.use_mipmaps   <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hdl/tllc_calc.sv]
// ----------------------------------------------------------------------------
// tllc_calc
// Surface check and level arithmetic. Sides of valid surfaces have a
// power-of-two height (and width where the layout needs it), so every size
// is a shift of the width; offsets come from the 16-bit mip offset table.
// ----------------------------------------------------------------------------
module tllc_calc (
    input  tllc_pkg::t_cfg               i_cfg,
    input  logic [tllc_pkg::LEVEL_W-1:0] i_level,
    output tllc_pkg::t_result            o_res
);
    import tllc_pkg::*;

    // Power of two from 8 to 1024
    function automatic logic side_pow2_ok(input logic [SIDE_W-1:0] v);
        return (v >= 11'd8) && (v <= 11'd1024) && ((v & (v - 11'd1)) == '0);
    endfunction

    // Index of the highest set bit
    function automatic logic [LEVEL_W-1:0] floor_log2(input logic [SIDE_W-1:0] v);
        logic [LEVEL_W-1:0] r;
        r = '0;
        for (int i = 0; i < SIDE_W; i++) begin
            if (v[i]) r = LEVEL_W'(i);
        end
        return r;
    endfunction

    // Level offsets for 16-bit texels, by log2 of the level side
    function automatic logic [OFFSET_W-1:0] offset16(input logic [LEVEL_W-1:0] e);
        logic [OFFSET_W-1:0] r;
        case (e)
            4'd0:    r = 20'h00006;
            4'd1:    r = 20'h00008;
            4'd2:    r = 20'h00010;
            4'd3:    r = 20'h00030;
            4'd4:    r = 20'h000b0;
            4'd5:    r = 20'h002b0;
            4'd6:    r = 20'h00ab0;
            4'd7:    r = 20'h02ab0;
            4'd8:    r = 20'h0aab0;
            4'd9:    r = 20'h2aab0;
            default: r = 20'haaab0;
        endcase
        return r;
    endfunction

    // Scale the 16-bit offset down for VQ, 4-bit and 8-bit data
    function automatic logic [OFFSET_W-1:0] level_pos(input logic [LEVEL_W-1:0] e,
                                                      input t_fmt fmt, input t_lay lay);
        logic [OFFSET_W-1:0] off;
        off = offset16(e);
        if (lay == LAY_VQ)        return off >> 3;
        else if (fmt == FMT_PAL4) return off >> 2;
        else if (fmt == FMT_PAL8) return off >> 1;
        else                      return off;
    endfunction

    // Texel count to bytes, rounded up to bytes or to 64-bit VQ indexes
    function automatic logic [BYTES_W-1:0] packed_bytes(input logic [AREA_W-1:0] area,
                                                        input t_fmt fmt, input t_lay lay);
        logic [24:0] bits;
        logic [24:0] rnd;
        case (fmt)
            FMT_PAL4: bits = {2'b00, area, 2'b00};
            FMT_PAL8: bits = {1'b0, area, 3'b000};
            default:  bits = {area, 4'b0000};
        endcase
        if (lay == LAY_VQ) rnd = (bits + 25'd63) >> 6;
        else               rnd = (bits + 25'd7) >> 3;
        return rnd[BYTES_W-1:0];
    endfunction

    t_fmt                  w_fmt;
    t_lay                  w_lay;
    logic                  w_mip;
    logic                  w_pal;
    logic                  w_w_ok;
    logic                  w_h_ok;
    logic                  w_stride_w_ok;
    t_status               w_surf_st;
    logic [LEVEL_W-1:0]    w_wlog;
    logic [LEVEL_W-1:0]    w_hlog;
    logic [COUNT_W-1:0]    w_count;
    logic [CODEBOOK_W-1:0] w_codebook;
    logic [AREA_W-1:0]     w_top_area;
    logic [BYTES_W-1:0]    w_top_bytes;
    logic [BYTES_W-1:0]    w_data;
    logic [BYTES_W-1:0]    w_total;
    logic [SIDE_W-1:0]     w_lw;
    logic [SIDE_W-1:0]     w_lh;
    logic [LEVEL_W-1:0]    w_lh_log;
    logic [LEVEL_W-1:0]    w_lw_log;
    logic [AREA_W-1:0]     w_lvl_area;
    logic [BYTES_W-1:0]    w_lvl_bytes;
    logic [OFFSET_W-1:0]   w_lvl_off;

    assign w_fmt = i_cfg.pixel_format;
    assign w_lay = i_cfg.memory_layout;
    assign w_mip = i_cfg.use_mipmaps;
    assign w_pal = (w_fmt == FMT_PAL4) || (w_fmt == FMT_PAL8);

    // Check the surface description
    assign w_w_ok        = side_pow2_ok(i_cfg.tex_width);
    assign w_h_ok        = side_pow2_ok(i_cfg.tex_height);
    assign w_stride_w_ok = (i_cfg.tex_width >= 11'd32) && (i_cfg.tex_width <= 11'd992)
                           && (i_cfg.tex_width[4:0] == 5'd0);

    always_comb begin
        w_surf_st = ST_OK;
        if ((w_fmt == FMT_INVALID) || (w_lay == LAY_INVALID)) begin
            w_surf_st = ST_INVALID_ARG;
        end else if ((w_lay == LAY_STRIDE) ? !(w_stride_w_ok && w_h_ok)
                                           : !(w_w_ok && w_h_ok)) begin
            w_surf_st = ST_INVALID_ARG;
        end else if (w_pal && (w_lay != LAY_TWIDDLED)) begin
            w_surf_st = ST_NOT_SUPPORTED;
        end else if ((w_lay == LAY_VQ) && (w_fmt > FMT_BUMP)) begin
            w_surf_st = ST_NOT_SUPPORTED;
        end else if (w_mip && (i_cfg.tex_width != i_cfg.tex_height)) begin
            w_surf_st = ST_INVALID_ARG;
        end else if (w_mip && (w_lay == LAY_STRIDE)) begin
            w_surf_st = ST_NOT_SUPPORTED;
        end
    end

    // Surface-wide sizes
    assign w_wlog      = floor_log2(i_cfg.tex_width);
    assign w_hlog      = floor_log2(i_cfg.tex_height);
    assign w_count     = w_mip ? (w_wlog + 4'd1) : 4'd1;
    assign w_codebook  = (w_lay == LAY_VQ) ? CODEBOOK_BYTES : '0;
    assign w_top_area  = AREA_W'(i_cfg.tex_width) << w_hlog;
    assign w_top_bytes = packed_bytes(w_top_area, w_fmt, w_lay);
    assign w_data      = w_mip ? (BYTES_W'(level_pos(w_wlog, w_fmt, w_lay)) + w_top_bytes)
                               : w_top_bytes;
    assign w_total     = BYTES_W'(w_codebook) + w_data;

    // Sizes of the requested level
    assign w_lw        = i_cfg.tex_width >> i_level;
    assign w_lh        = i_cfg.tex_height >> i_level;
    assign w_lh_log    = w_hlog - i_level;
    assign w_lw_log    = w_wlog - i_level;
    assign w_lvl_area  = AREA_W'(w_lw) << w_lh_log;
    assign w_lvl_bytes = packed_bytes(w_lvl_area, w_fmt, w_lay);
    assign w_lvl_off   = w_mip ? (OFFSET_W'(w_codebook) + level_pos(w_lw_log, w_fmt, w_lay))
                               : OFFSET_W'(w_codebook);

    // Zero every field but the status on error
    always_comb begin
        o_res = '0;
        if (w_surf_st != ST_OK) begin
            o_res.status = w_surf_st;
        end else if (i_level >= w_count) begin
            o_res.status = ST_LEVEL_RANGE;
        end else begin
            o_res.status         = ST_OK;
            o_res.level_width    = w_lw;
            o_res.level_height   = w_lh;
            o_res.level_offset   = w_lvl_off;
            o_res.level_bytes    = w_lvl_bytes;
            o_res.total_bytes    = w_total;
            o_res.data_bytes     = w_data;
            o_res.codebook_bytes = w_codebook;
            o_res.level_count    = w_count;
        end
    end

endmodule

[hdl/texture_level_layout_calc_core.sv]
// ----------------------------------------------------------------------------
// texture_level_layout_calc_core
// Answers mip level layout requests for the surface held in configuration.
// ----------------------------------------------------------------------------
// Result path: the request register captures an accepted request, then the
//   result register takes the layout arithmetic on it.
// Throughput: one request per cycle while results are taken; the request
//   register refills whenever the result register is empty or being drained.
// Reset: synchronous, active low; clears both stage valids and loads the
//   surface registers with an 8x8 twiddled ARGB1555 surface, no mipmaps.
module texture_level_layout_calc_core (
    input  logic     i_clk,
    input  logic     i_rst_n,
    tllc_cfg_if.sink i_cfg,
    tllc_req_if.sink i_req,
    tllc_res_if.source o_res
);
    import tllc_pkg::*;

    t_cfg               w_cfg;
    t_result            w_res;
    logic               w_out_load;
    logic               w_in_load;
    logic               r_s1_valid;
    logic [LEVEL_W-1:0] r_s1_level;
    logic               r_out_valid;
    t_result            r_res;

    tllc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    tllc_calc u_calc (
        .i_cfg   (w_cfg),
        .i_level (r_s1_level),
        .o_res   (w_res)
    );

    // Stage enables: result register loads when empty or being drained
    assign w_out_load  = !r_out_valid || o_res.ready;
    assign w_in_load   = !r_s1_valid || w_out_load;
    assign i_req.ready = w_in_load;

    // Request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_load) begin
            r_s1_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_load && i_req.valid) begin
            r_s1_level <= i_req.level;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load && r_s1_valid) begin
            r_res <= w_res;
        end
    end

    // Drive the result channel
    assign o_res.valid          = r_out_valid;
    assign o_res.status         = r_res.status;
    assign o_res.level_width    = r_res.level_width;
    assign o_res.level_height   = r_res.level_height;
    assign o_res.level_offset   = r_res.level_offset;
    assign o_res.level_bytes    = r_res.level_bytes;
    assign o_res.total_bytes    = r_res.total_bytes;
    assign o_res.data_bytes     = r_res.data_bytes;
    assign o_res.codebook_bytes = r_res.codebook_bytes;
    assign o_res.level_count    = r_res.level_count;

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks texture_level_layout_calc_core. The surface registers are loaded
// while the core is idle, then level requests stream in under random sender
// gaps and receiver stalls. Each answer is compared field by field with an
// independent layout calculation. Directed surfaces come first: size
// extremes, every format and layout, and each rejection rule. Random
// surfaces follow, mostly legal ones with some illegal ones mixed in.
// ----------------------------------------------------------------------------
module testbench;
    import tllc_pkg::*;

    localparam int RANDOM_ITEMS = 500;
    localparam int CALM_AFTER   = 420;
    localparam int REG_SLOTS    = 5;    // first unused register index
    localparam int DRAIN_CYCLES = 8;
    localparam int TIMEOUT_NS   = 5_000_000;

    // Byte offsets of 16-bit mip chains, indexed by log2 of the level side
    localparam int MIP_OFFSET16 [0:10] = '{
        'h00006, 'h00008, 'h00010, 'h00030, 'h000b0, 'h002b0,
        'h00ab0, 'h02ab0, 'h0aab0, 'h2aab0, 'haaab0
    };

    // Shadow of the surface registers plus the queue of predicted answers
    class layout_scoreboard;
        t_cfg    surf;
        t_result expected_layouts[$];
        int      failures;
        int      checked;
        int      ok_count;

        function new();
            surf.tex_width     = SIDE_W'(8);
            surf.tex_height    = SIDE_W'(8);
            surf.pixel_format  = FMT_ARGB1555;
            surf.memory_layout = LAY_TWIDDLED;
            surf.use_mipmaps   = 1'b0;
            failures = 0;
            checked  = 0;
            ok_count = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx,
                                     logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TEX_WIDTH:     surf.tex_width     = data[SIDE_W-1:0];
                REG_TEX_HEIGHT:    surf.tex_height    = data[SIDE_W-1:0];
                REG_PIXEL_FORMAT:  surf.pixel_format  = t_fmt'(data[2:0]);
                REG_MEMORY_LAYOUT: surf.memory_layout = t_lay'(data[1:0]);
                REG_USE_MIPMAPS:   surf.use_mipmaps   = data[0];
                default: ;
            endcase
        endfunction

        function bit side_pow2_ok(int v);
            return v >= 8 && v <= 1024 && (v & (v - 1)) == 0;
        endfunction

        function longint packed_bytes(int w, int h);
            longint bits;
            bits = longint'(w) * h;
            if (surf.pixel_format == FMT_PAL4)
                bits = bits * 4;
            else if (surf.pixel_format == FMT_PAL8)
                bits = bits * 8;
            else
                bits = bits * 16;
            if (surf.memory_layout == LAY_VQ)
                return (bits + 63) / 64;
            return (bits + 7) / 8;
        endfunction

        // Scale the 16-bit table down for VQ and palette data
        function longint level_pos(int e);
            longint off;
            off = MIP_OFFSET16[e > 10 ? 10 : e];
            if (surf.memory_layout == LAY_VQ)
                return off / 8;
            if (surf.pixel_format == FMT_PAL4)
                return off / 4;
            if (surf.pixel_format == FMT_PAL8)
                return off / 2;
            return off;
        endfunction

        function t_status surface_status();
            int   w;
            int   h;
            bit   pal;
            t_lay lay;
            w   = surf.tex_width;
            h   = surf.tex_height;
            lay = surf.memory_layout;
            pal = surf.pixel_format == FMT_PAL4 || surf.pixel_format == FMT_PAL8;
            if (surf.pixel_format > FMT_PAL8 || lay > LAY_VQ)
                return ST_INVALID_ARG;
            if (lay == LAY_STRIDE) begin
                if (w < 32 || w > 992 || (w % 32) != 0 || !side_pow2_ok(h))
                    return ST_INVALID_ARG;
            end else if (!side_pow2_ok(w) || !side_pow2_ok(h)) begin
                return ST_INVALID_ARG;
            end
            if (pal && lay != LAY_TWIDDLED)
                return ST_NOT_SUPPORTED;
            if (lay == LAY_VQ && surf.pixel_format > FMT_BUMP)
                return ST_NOT_SUPPORTED;
            if (surf.use_mipmaps && w != h)
                return ST_INVALID_ARG;
            if (surf.use_mipmaps && lay != LAY_TWIDDLED && lay != LAY_VQ)
                return ST_NOT_SUPPORTED;
            return ST_OK;
        endfunction

        function t_result layout_for(logic [LEVEL_W-1:0] level);
            t_result r;
            t_status st;
            int      w;
            int      wlog;
            int      count;
            longint  codebook;
            longint  top;
            longint  data;
            longint  loff;
            r  = '0;
            st = surface_status();
            if (st != ST_OK) begin
                r.status = st;
                return r;
            end
            w    = surf.tex_width;
            wlog = 0;
            while (w > 1) begin
                w = w >> 1;
                wlog++;
            end
            count    = surf.use_mipmaps ? wlog + 1 : 1;
            codebook = (surf.memory_layout == LAY_VQ) ? 2048 : 0;
            top      = packed_bytes(surf.tex_width, surf.tex_height);
            data     = surf.use_mipmaps ? level_pos(wlog) + top : top;
            if (level >= count) begin
                r.status = ST_LEVEL_RANGE;
                return r;
            end
            loff = surf.use_mipmaps ? codebook + level_pos(wlog - level) : codebook;
            r.status         = ST_OK;
            r.level_width    = surf.tex_width >> level;
            r.level_height   = surf.tex_height >> level;
            r.level_offset   = OFFSET_W'(loff);
            r.level_bytes    = BYTES_W'(packed_bytes(surf.tex_width >> level,
                                                     surf.tex_height >> level));
            r.total_bytes    = BYTES_W'(codebook + data);
            r.data_bytes     = BYTES_W'(data);
            r.codebook_bytes = CODEBOOK_W'(codebook);
            r.level_count    = COUNT_W'(count);
            return r;
        endfunction

        function void note_request(logic [LEVEL_W-1:0] level);
            expected_layouts.push_back(layout_for(level));
        endfunction

        function void check_field(string name, longint want, longint got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
                failures++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_layouts.size() == 0) begin
                $display("%0t: result with no request pending, expected none, actual status %0d",
                         $time, got.status);
                failures++;
                return;
            end
            want = expected_layouts.pop_front();
            check_field("status",         want.status,         got.status);
            check_field("level_width",    want.level_width,    got.level_width);
            check_field("level_height",   want.level_height,   got.level_height);
            check_field("level_offset",   want.level_offset,   got.level_offset);
            check_field("level_bytes",    want.level_bytes,    got.level_bytes);
            check_field("total_bytes",    want.total_bytes,    got.total_bytes);
            check_field("data_bytes",     want.data_bytes,     got.data_bytes);
            check_field("codebook_bytes", want.codebook_bytes, got.codebook_bytes);
            check_field("level_count",    want.level_count,    got.level_count);
            checked++;
            if (want.status == ST_OK)
                ok_count++;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   calm;
    bit   gaps_on;
    int   surfaces;

    layout_scoreboard board;

    tllc_cfg_if cfg_ch ();
    tllc_req_if req_ch ();
    tllc_res_if res_ch ();

    texture_level_layout_calc_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Give up after a generous fixed time
    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results still outstanding", board.expected_layouts.size());
        $display("TB_ERROR");
        $finish;
    end

    // Observe all three channels at each edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready)
                board.write_register(cfg_ch.index, cfg_ch.data);
            if (req_ch.valid && req_ch.ready)
                board.note_request(req_ch.level);
            if (res_ch.valid && res_ch.ready)
                board.check_result(t_result'({res_ch.status, res_ch.level_width,
                    res_ch.level_height, res_ch.level_offset, res_ch.level_bytes,
                    res_ch.total_bytes, res_ch.data_bytes, res_ch.codebook_bytes,
                    res_ch.level_count}));
        end
    end

    // Stall the result channel in random bursts until the calm tail
    initial begin
        res_ch.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Issue one level request, then maybe hold off the next one
    task automatic push_level(input int lv);
        req_ch.valid <= 1'b1;
        req_ch.level <= LEVEL_W'(lv);
        do @(posedge i_clk); while (!req_ch.ready);
        if (gaps_on && !calm && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    // Drop the request valid and wait for every answer to come back
    task automatic drain();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (board.expected_layouts.size() != 0);
    endtask

    // Hold a register write until the channel takes it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    // Fill the unused upper bits of a narrow register with noise
    function automatic logic [CFG_DATA_W-1:0] junk_above(int value, int bits);
        return CFG_DATA_W'($urandom_range(0, 2047) << bits) | CFG_DATA_W'(value);
    endfunction

    // Load a whole surface while the core is idle
    task automatic apply_surface(input int w, input int h, input t_fmt fmt,
                                 input t_lay lay, input bit mip);
        drain();
        write_reg(REG_TEX_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_TEX_HEIGHT, CFG_DATA_W'(h));
        write_reg(REG_PIXEL_FORMAT, junk_above(fmt, 3));
        write_reg(REG_MEMORY_LAYOUT, junk_above(lay, 2));
        write_reg(REG_USE_MIPMAPS, junk_above(mip, 1));
        // writes to unused indexes must leave the surface alone
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_IDX_W'(REG_SLOTS + $urandom_range(0, 2)),
                      CFG_DATA_W'($urandom_range(0, 2047)));
        cfg_ch.valid <= 1'b0;
        surfaces++;
    endtask

    initial begin : stimulus
        int   w;
        int   h;
        int   kind;
        int   top_level;
        int   items;
        int   n;
        bit   mip;
        t_fmt fmt;
        t_lay lay;

        board = new();
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data  <= '0;
        req_ch.valid <= 1'b0;
        req_ch.level <= '0;
        i_rst_n      <= 1'b0;
        calm     = 1'b0;
        gaps_on  = 1'b1;
        surfaces = 0;
        items    = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Surface left by reset
        push_level(0);
        push_level(15);
        // Largest mip chains, last level and one past it
        apply_surface(1024, 1024, FMT_ARGB4444, LAY_TWIDDLED, 1'b1);
        push_level(0);
        push_level(10);
        push_level(11);
        apply_surface(1024, 1024, FMT_BUMP, LAY_VQ, 1'b1);
        push_level(0);
        push_level(10);
        // Palette formats
        apply_surface(8, 8, FMT_PAL4, LAY_TWIDDLED, 1'b1);
        push_level(3);
        push_level(4);
        apply_surface(1024, 8, FMT_PAL8, LAY_TWIDDLED, 1'b0);
        push_level(0);
        push_level(1);
        // Stride width extremes
        apply_surface(992, 1024, FMT_RGB565, LAY_STRIDE, 1'b0);
        push_level(0);
        apply_surface(32, 8, FMT_YUV422, LAY_STRIDE, 1'b0);
        push_level(0);
        // Invalid format and invalid layout codes
        apply_surface(64, 64, FMT_INVALID, LAY_TWIDDLED, 1'b0);
        push_level(0);
        apply_surface(64, 64, FMT_ARGB1555, LAY_INVALID, 1'b0);
        push_level(0);
        // Bad sides
        apply_surface(0, 0, FMT_ARGB1555, LAY_TWIDDLED, 1'b0);
        push_level(0);
        apply_surface(12, 8, FMT_RGB565, LAY_VQ, 1'b0);
        push_level(0);
        apply_surface(48, 8, FMT_RGB565, LAY_STRIDE, 1'b0);
        push_level(0);
        apply_surface(1024, 8, FMT_RGB565, LAY_STRIDE, 1'b0);
        push_level(0);
        // Palette outside the twiddled layout
        apply_surface(64, 64, FMT_PAL4, LAY_STRIDE, 1'b0);
        push_level(0);
        apply_surface(64, 64, FMT_PAL8, LAY_VQ, 1'b0);
        push_level(0);
        // Mipmaps on a non-square surface and on the stride layout
        apply_surface(64, 32, FMT_ARGB1555, LAY_TWIDDLED, 1'b1);
        push_level(0);
        apply_surface(64, 64, FMT_ARGB1555, LAY_STRIDE, 1'b1);
        push_level(0);
        apply_surface(8, 16, FMT_ARGB4444, LAY_VQ, 1'b0);
        push_level(0);

        // Random surfaces: mostly legal, some rejected
        while (items < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            mip  = $urandom_range(0, 1);
            w    = 1 << $urandom_range(3, 10);
            h    = 1 << $urandom_range(3, 10);
            if (kind < 7) begin
                lay = t_lay'($urandom_range(0, 2));
                fmt = t_fmt'((lay == LAY_TWIDDLED) ? $urandom_range(0, 6)
                                                   : $urandom_range(0, 4));
                if (lay == LAY_STRIDE) begin
                    w   = 32 * $urandom_range(1, 31);
                    mip = 1'b0;
                end else if (mip) begin
                    w = h;
                end
            end else begin
                lay = t_lay'($urandom_range(0, 3));
                fmt = t_fmt'($urandom_range(0, 7));
                if (kind == 9) begin
                    w = $urandom_range(0, 1024);
                    h = $urandom_range(0, 1024);
                end
            end
            calm    = items >= CALM_AFTER;
            gaps_on = $urandom_range(0, 2) != 0;
            apply_surface(w, h, fmt, lay, mip);
            top_level = (mip && w > 1) ? $clog2(w) : 0;
            n = $urandom_range(15, 35);
            repeat (n) begin
                if ($urandom_range(0, 3) == 0)
                    push_level($urandom_range(0, 15));
                else
                    push_level($urandom_range(0, top_level));
            end
            items += n;
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Checked %0d level answers over %0d surface settings", board.checked,
                 surfaces);
        $display("%0d answers ok, %0d with an error status", board.ok_count,
                 board.checked - board.ok_count);
        if (board.failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[files.f]
hdl/tllc_pkg.sv
hdl/tllc_if.sv
hdl/tllc_cfg_regs.sv
hdl/tllc_calc.sv
hdl/texture_level_layout_calc_core.sv
test/testbench.sv
